// File: design/wav_stream_sample_extractor_macros.svh
// Assertion macros shared by wavx_fifo and the top-level extractor.
`ifndef WAV_STREAM_SAMPLE_EXTRACTOR_MACROS_SVH
`define WAV_STREAM_SAMPLE_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define WAVX_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WAVX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WAVX_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define WAVX_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: design/wavx_pkg.sv
package wavx_pkg;

    localparam int WAVX_FIFO_DEPTH = 8;

    localparam logic [3:0] PH_RIFF     = 4'd0;
    localparam logic [3:0] PH_RSIZE    = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_CID      = 4'd3;
    localparam logic [3:0] PH_SZ_FMT   = 4'd4;
    localparam logic [3:0] PH_SZ_DATA  = 4'd5;
    localparam logic [3:0] PH_SZ_OTHER = 4'd6;
    localparam logic [3:0] PH_FMT_A    = 4'd7;
    localparam logic [3:0] PH_FMT_B    = 4'd8;
    localparam logic [3:0] PH_DATA     = 4'd9;
    localparam logic [3:0] PH_SKIP     = 4'd10;
    localparam logic [3:0] PH_PAD      = 4'd11;
    localparam logic [3:0] PH_DRAIN    = 4'd12;

    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
    localparam logic [2:0] ERR_TRUNC      = 3'd3;
    localparam logic [2:0] ERR_ENC        = 3'd4;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd5;
    localparam logic [2:0] ERR_SIZE       = 3'd6;
    localparam logic [2:0] ERR_DEPTH      = 3'd7;

    localparam logic [15:0] ENC_PCM   = 16'd1;
    localparam logic [15:0] ENC_FLOAT = 16'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample_bits;
        logic [2:0]  error_code;
        logic [31:0] sample_rate;
        logic [15:0] channels;
    } t_res;

    typedef struct packed {
        logic        samp_v;
        logic        fin_v;
        logic [31:0] raw;
        logic [15:0] enc;
        logic [15:0] depth;
        logic [3:0]  phase;
        logic [2:0]  idx;
        logic [15:0] chan;
        logic [31:0] rate;
        logic        seen;
        logic [2:0]  err;
    } t_s1;

    function automatic logic conv_ok(input logic [15:0] enc, input logic [15:0] depth);
        logic ok;
        ok = 1'b0;
        if (enc == ENC_PCM) begin
            ok = (depth == 16'd8) || (depth == 16'd16) || (depth == 16'd24) ||
                 (depth == 16'd32);
        end else if (enc == ENC_FLOAT) begin
            ok = (depth == 16'd32);
        end
        return ok;
    endfunction

endpackage

// File: design/wavx_fifo.sv
`include "wav_stream_sample_extractor_macros.svh"

module wavx_fifo import wavx_pkg::*; #(
    parameter int DEPTH = WAVX_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push_a,
    input  t_res                       i_data_a,
    input  logic                       i_push_b,
    input  t_res                       i_data_b,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_res                       o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_res            r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   w_wp1;
    logic [PW-1:0]   w_wp2;
    logic [PW-1:0]   w_addr_b;
    logic [PW-1:0]   n_wp;
    logic [CW:0]     w_total;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wp1    = ptr_inc(r_wp);
    assign w_wp2    = ptr_inc(w_wp1);
    assign w_addr_b = i_push_a ? w_wp1 : r_wp;
    assign n_wp     = (i_push_a && i_push_b) ? w_wp2 :
                      (i_push_a || i_push_b) ? w_wp1 : r_wp;
    assign w_total  = {1'b0, r_count} + (CW+1)'(i_push_a) + (CW+1)'(i_push_b);

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[w_addr_b] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            r_count <= CW'(w_total - (CW+1)'(i_pop));
        end
    end

    `WAVX_ASSERT_IMPL(a_fifo_no_overflow, i_clk, i_rst_n, i_push_a || i_push_b,
        w_total <= (CW+1)'(DEPTH))
    `WAVX_ASSERT_NEXT(a_fifo_pop_dec, i_clk, i_rst_n, i_pop && !i_push_a && !i_push_b,
        r_count == $past(r_count) - 1'b1)
    `WAVX_ASSERT_NEXT(a_fifo_push_two, i_clk, i_rst_n, i_push_a && i_push_b && !i_pop,
        r_count == $past(r_count) + 2'd2)

endmodule

// File: design/wavx_conv.sv
module wavx_conv import wavx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_s1        i_s1,
    output logic       o_push_a,
    output t_res       o_res_a,
    output logic       o_push_b,
    output t_res       o_res_b,
    output logic [1:0] o_pend
);

    typedef struct packed {
        logic        samp_v;
        logic        fin_v;
        logic        is_float;
        logic [31:0] raw;
        logic        neg;
        logic        zero;
        logic [31:0] norm;
        logic [4:0]  lead;
        logic [4:0]  frac;
        logic [2:0]  code;
        logic [31:0] rate;
        logic [15:0] chan;
    } t_stage;

    t_stage      r_a;
    t_stage      n_a;
    logic [5:0]  w_d;
    logic [31:0] w_mask;
    logic [31:0] w_x;
    logic        w_neg;
    logic [31:0] w_mag;
    logic [4:0]  w_lead;
    logic [23:0] w_mant;
    logic        w_up;
    logic [24:0] w_sum;
    logic [7:0]  w_exp;
    logic [31:0] w_bits;

    function automatic logic [2:0] final_code(input t_s1 s);
        logic [2:0] c;
        if (s.err == ERR_NOT_RIFF || s.err == ERR_NOT_WAVE) begin
            c = s.err;
        end else if (s.phase != PH_CID || s.idx != 3'd0) begin
            c = ERR_TRUNC;
        end else if (s.enc != ENC_PCM && s.enc != ENC_FLOAT) begin
            c = ERR_ENC;
        end else if (s.chan == '0 || s.rate == '0 || s.depth == '0 || !s.seen) begin
            c = ERR_INCOMPLETE;
        end else if (s.depth[15:3] == '0 || s.err == ERR_SIZE) begin
            c = ERR_SIZE;
        end else if (!conv_ok(s.enc, s.depth)) begin
            c = ERR_DEPTH;
        end else begin
            c = ERR_NONE;
        end
        return c;
    endfunction

    assign w_d    = i_s1.depth[5:0];
    assign w_mask = ~(32'hFFFF_FFFF << w_d);
    assign w_x    = (i_s1.raw ^ ((w_d == 6'd8) ? 32'h0000_0080 : 32'h0)) & w_mask;
    assign w_neg  = w_x[5'(w_d - 6'd1)];
    assign w_mag  = w_neg ? ((32'd0 - w_x) & w_mask) : w_x;

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_mag[i]) begin
                w_lead = 5'(i);
            end
        end
    end

    always_comb begin
        n_a.samp_v   = i_s1.samp_v;
        n_a.fin_v    = i_s1.fin_v;
        n_a.is_float = (i_s1.enc == ENC_FLOAT);
        n_a.raw      = i_s1.raw;
        n_a.neg      = w_neg;
        n_a.zero     = (w_mag == '0);
        n_a.norm     = w_mag << (5'd31 - w_lead);
        n_a.lead     = w_lead;
        n_a.frac     = 5'(w_d - 6'd1);
        n_a.code     = final_code(i_s1);
        n_a.rate     = i_s1.rate;
        n_a.chan     = i_s1.chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.samp_v <= 1'b0;
            r_a.fin_v  <= 1'b0;
        end else begin
            r_a.samp_v <= n_a.samp_v;
            r_a.fin_v  <= n_a.fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a.is_float <= n_a.is_float;
        r_a.raw      <= n_a.raw;
        r_a.neg      <= n_a.neg;
        r_a.zero     <= n_a.zero;
        r_a.norm     <= n_a.norm;
        r_a.lead     <= n_a.lead;
        r_a.frac     <= n_a.frac;
        r_a.code     <= n_a.code;
        r_a.rate     <= n_a.rate;
        r_a.chan     <= n_a.chan;
    end

    assign w_mant = r_a.norm[31:8];
    assign w_up   = r_a.norm[7] && ((r_a.norm[6:0] != '0) || w_mant[0]);
    assign w_sum  = {1'b0, w_mant} + 25'(w_up);
    assign w_exp  = 8'(r_a.lead) + 8'd127 - 8'(r_a.frac) + 8'(w_sum[24]);

    always_comb begin
        if (r_a.is_float) begin
            w_bits = r_a.raw;
        end else if (r_a.zero) begin
            w_bits = '0;
        end else begin
            w_bits = {r_a.neg, w_exp, w_sum[24] ? 23'd0 : w_sum[22:0]};
        end
    end

    assign o_push_a            = r_a.samp_v;
    assign o_res_a.kind        = KIND_SAMPLE;
    assign o_res_a.sample_bits = w_bits;
    assign o_res_a.error_code  = ERR_NONE;
    assign o_res_a.sample_rate = '0;
    assign o_res_a.channels    = '0;

    assign o_push_b            = r_a.fin_v;
    assign o_res_b.kind        = (r_a.code == ERR_NONE) ? KIND_OK : KIND_ERR;
    assign o_res_b.sample_bits = '0;
    assign o_res_b.error_code  = r_a.code;
    assign o_res_b.sample_rate = r_a.rate;
    assign o_res_b.channels    = r_a.chan;

    assign o_pend = 2'(r_a.samp_v) + 2'(r_a.fin_v);

endmodule

// File: design/wav_stream_sample_extractor.sv
// Byte-stream parser for RIFF/WAVE files that turns the audio data into
// IEEE single-precision samples.
// The input channel carries one file byte per transaction, with a flag
// on the final byte. The output channel carries one result per transaction:
// a converted sample, or on the final byte a success or error report with
// the sample rate and channel count from the format chunk.
// One input byte is taken per clock cycle while o_stall is low. The final byte
// of a file may yield a sample and then the report, as two output transactions.
// A result passes from its accepted byte through a parse stage, a normalize
// stage and a round stage into an output queue.
// When the receiver stalls, the queue fills and the input stalls once the
// queue cannot take the results of every byte still in flight.
// Reset clears the parser, the pipeline and the queue; the block then waits
// for the RIFF tag. After each final byte the parser restarts the same way.
`include "wav_stream_sample_extractor_macros.svh"

module wav_stream_sample_extractor import wavx_pkg::*; #(
    parameter int FIFO_DEPTH = WAVX_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_sample_bits,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_channels
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_word, n_word;
    logic [31:0] r_left, n_left;
    logic        r_pad, n_pad;
    logic [15:0] r_enc, n_enc;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic        r_seen, n_seen;
    logic [2:0]  r_err, n_err;
    logic [12:0] r_bps, n_bps;
    logic [12:0] r_mod, n_mod;
    t_s1         r_s1, n_s1;

    logic        w_acc;
    logic [31:0] w_full;
    logic        w_word_done;
    logic [31:0] w_left_dec;
    logic [12:0] w_mod_inc;
    logic [12:0] w_mod_next;
    logic [3:0]  w_idx_inc;
    logic        w_conv;

    logic        w_push_a, w_push_b;
    t_res        w_res_a, w_res_b;
    logic [1:0]  w_pend;
    logic        w_fifo_valid;
    t_res        w_fifo_data;
    logic [CW-1:0] w_count;
    logic [CW:0] w_outstanding;

    assign w_acc       = i_valid && !o_stall;
    assign w_full      = r_word | ({24'd0, i_data_byte} << {r_idx[1:0], 3'b000});
    assign w_word_done = (r_idx[1:0] == 2'd3);
    assign w_left_dec  = r_left - 32'd1;
    assign w_mod_inc   = r_mod + 13'd1;
    assign w_mod_next  = (w_mod_inc == r_bps) ? 13'd0 : w_mod_inc;
    assign w_idx_inc   = {1'b0, r_idx} + 4'd1;
    assign w_conv      = conv_ok(r_enc, r_depth);

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_word  = r_word;
        n_left  = r_left;
        n_pad   = r_pad;
        n_enc   = r_enc;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_depth = r_depth;
        n_seen  = r_seen;
        n_err   = r_err;
        n_bps   = r_bps;
        n_mod   = r_mod;
        n_s1    = r_s1;
        n_s1.samp_v = 1'b0;
        n_s1.fin_v  = 1'b0;

        if (w_acc) begin
            case (r_phase)
                PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID,
                PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
                    if (w_word_done) begin
                        n_word = '0;
                        n_idx  = '0;
                        case (r_phase)
                            PH_RIFF: begin
                                if (w_full == TAG_RIFF) begin
                                    n_phase = PH_RSIZE;
                                end else begin
                                    n_err   = ERR_NOT_RIFF;
                                    n_phase = PH_DRAIN;
                                end
                            end
                            PH_RSIZE: begin
                                n_phase = PH_WAVE;
                            end
                            PH_WAVE: begin
                                if (w_full == TAG_WAVE) begin
                                    n_phase = PH_CID;
                                end else begin
                                    n_err   = ERR_NOT_WAVE;
                                    n_phase = PH_DRAIN;
                                end
                            end
                            PH_CID: begin
                                if (w_full == TAG_FMT) begin
                                    n_phase = PH_SZ_FMT;
                                end else if (w_full == TAG_DATA) begin
                                    n_phase = PH_SZ_DATA;
                                end else begin
                                    n_phase = PH_SZ_OTHER;
                                end
                            end
                            PH_SZ_FMT: begin
                                if (w_full > 32'd16) begin
                                    n_left = w_full - 32'd16;
                                    n_pad  = w_full[0];
                                end else begin
                                    n_left = '0;
                                    n_pad  = 1'b0;
                                end
                                n_phase = PH_FMT_A;
                            end
                            default: begin
                                n_left = w_full;
                                n_pad  = w_full[0];
                                if (r_phase == PH_SZ_DATA) begin
                                    n_bps = r_depth[15:3];
                                    n_mod = '0;
                                end
                                if (w_full == '0) begin
                                    n_phase = PH_CID;
                                end else if (r_phase == PH_SZ_DATA) begin
                                    n_phase = PH_DATA;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        endcase
                    end else begin
                        n_word = w_full;
                        n_idx  = r_idx + 3'd1;
                    end
                end
                PH_FMT_A: begin
                    case (r_idx)
                        3'd0: n_enc = {8'd0, i_data_byte};
                        3'd1: n_enc[15:8] = i_data_byte;
                        3'd2: n_chan = {8'd0, i_data_byte};
                        3'd3: n_chan[15:8] = i_data_byte;
                        3'd4: n_rate = {24'd0, i_data_byte};
                        3'd5: n_rate[15:8] = i_data_byte;
                        3'd6: n_rate[23:16] = i_data_byte;
                        default: n_rate[31:24] = i_data_byte;
                    endcase
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_phase = PH_FMT_B;
                    end
                end
                PH_FMT_B: begin
                    if (r_idx == 3'd6) begin
                        n_depth = {8'd0, i_data_byte};
                    end else if (r_idx == 3'd7) begin
                        n_depth[15:8] = i_data_byte;
                    end
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        if (r_left != '0) begin
                            n_phase = PH_SKIP;
                        end else if (r_pad) begin
                            n_pad   = 1'b0;
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                end
                PH_DATA: begin
                    n_seen = 1'b1;
                    n_left = w_left_dec;
                    n_mod  = w_mod_next;
                    if (w_conv) begin
                        if ({9'd0, w_idx_inc} >= r_depth[15:3]) begin
                            n_s1.samp_v = 1'b1;
                            n_s1.raw    = w_full;
                            n_idx       = '0;
                            n_word      = '0;
                        end else begin
                            n_word = w_full;
                            n_idx  = r_idx + 3'd1;
                        end
                    end
                    if (w_left_dec == '0) begin
                        n_idx  = '0;
                        n_word = '0;
                        if (r_bps != '0 && w_mod_next != '0 && r_err == ERR_NONE) begin
                            n_err = ERR_SIZE;
                        end
                        if (r_pad) begin
                            n_pad   = 1'b0;
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                end
                PH_SKIP: begin
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        if (r_pad) begin
                            n_pad   = 1'b0;
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                end
                PH_PAD: begin
                    n_phase = PH_CID;
                end
                default: begin
                end
            endcase

            n_s1.fin_v = i_end_of_file;
            n_s1.enc   = n_enc;
            n_s1.depth = n_depth;
            n_s1.phase = n_phase;
            n_s1.idx   = n_idx;
            n_s1.chan  = n_chan;
            n_s1.rate  = n_rate;
            n_s1.seen  = n_seen;
            n_s1.err   = n_err;

            if (i_end_of_file) begin
                n_phase = PH_RIFF;
                n_idx   = '0;
                n_word  = '0;
                n_left  = '0;
                n_pad   = 1'b0;
                n_enc   = '0;
                n_chan  = '0;
                n_rate  = '0;
                n_depth = '0;
                n_seen  = 1'b0;
                n_err   = ERR_NONE;
                n_bps   = '0;
                n_mod   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_idx   <= '0;
            r_word  <= '0;
            r_left  <= '0;
            r_pad   <= 1'b0;
            r_enc   <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_depth <= '0;
            r_seen  <= 1'b0;
            r_err   <= ERR_NONE;
            r_bps   <= '0;
            r_mod   <= '0;
            r_s1.samp_v <= 1'b0;
            r_s1.fin_v  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_word  <= n_word;
            r_left  <= n_left;
            r_pad   <= n_pad;
            r_enc   <= n_enc;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_depth <= n_depth;
            r_seen  <= n_seen;
            r_err   <= n_err;
            r_bps   <= n_bps;
            r_mod   <= n_mod;
            r_s1.samp_v <= n_s1.samp_v;
            r_s1.fin_v  <= n_s1.fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.raw   <= n_s1.raw;
        r_s1.enc   <= n_s1.enc;
        r_s1.depth <= n_s1.depth;
        r_s1.phase <= n_s1.phase;
        r_s1.idx   <= n_s1.idx;
        r_s1.chan  <= n_s1.chan;
        r_s1.rate  <= n_s1.rate;
        r_s1.seen  <= n_s1.seen;
        r_s1.err   <= n_s1.err;
    end

    wavx_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (r_s1),
        .o_push_a (w_push_a),
        .o_res_a  (w_res_a),
        .o_push_b (w_push_b),
        .o_res_b  (w_res_b),
        .o_pend   (w_pend)
    );

    wavx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (w_push_a),
        .i_data_a (w_res_a),
        .i_push_b (w_push_b),
        .i_data_b (w_res_b),
        .i_pop    (w_fifo_valid && !i_stall),
        .o_valid  (w_fifo_valid),
        .o_data   (w_fifo_data),
        .o_count  (w_count)
    );

    assign w_outstanding = {1'b0, w_count} + (CW+1)'(w_pend) +
                           (CW+1)'(r_s1.samp_v) + (CW+1)'(r_s1.fin_v);
    assign o_stall = (w_outstanding > (CW+1)'(FIFO_DEPTH - 2));

    assign o_valid       = w_fifo_valid;
    assign o_kind        = w_fifo_data.kind;
    assign o_sample_bits = w_fifo_data.sample_bits;
    assign o_error_code  = w_fifo_data.error_code;
    assign o_sample_rate = w_fifo_data.sample_rate;
    assign o_channels    = w_fifo_data.channels;

    `WAVX_ASSERT_NEXT(a_eof_final, i_clk, i_rst_n, w_acc && i_end_of_file, r_s1.fin_v)
    `WAVX_ASSERT_NEXT(a_eof_restart, i_clk, i_rst_n, w_acc && i_end_of_file,
        r_phase == PH_RIFF && r_idx == 3'd0 && r_err == ERR_NONE)
    `WAVX_ASSERT_IMPL(a_sample_from_data, i_clk, i_rst_n, r_s1.samp_v,
        $past(r_phase) == PH_DATA)

endmodule
